// ----- design/scpt_pkg.sv -----
// Shared types and constants for the shape pair contact test block.
// No dependencies; every other file in this folder imports it.
package scpt_pkg;

    localparam int QONE            = 16384;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int SQRT_STAGES     = 32;
    localparam int DIV_STAGES      = 15;

    localparam logic signed [15:0] N_POS = 16'sd16384;
    localparam logic signed [15:0] N_NEG = -16'sd16384;

    typedef struct packed {
        logic               a_is_circle;
        logic signed [31:0] a_center_x;
        logic signed [31:0] a_center_y;
        logic        [30:0] a_size_x;
        logic        [30:0] a_size_y;
        logic               b_is_circle;
        logic signed [31:0] b_center_x;
        logic signed [31:0] b_center_y;
        logic        [30:0] b_size_x;
        logic        [30:0] b_size_y;
    } pair_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic        [31:0] depth;
    } result_t;

    // Word passed from front to back through the queue
    typedef struct packed {
        logic        done;      // result already final (box-box or early reject)
        result_t     res;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] r;
        logic        negx;
        logic        negy;
        logic        fb_y;      // fallback normal lies on the y axis
        logic        fb_neg;
    } work_t;

endpackage

// ----- design/scpt_front.sv -----
// Front end: takes a shape pair, classifies it and settles box-box and trivial misses.
// Depends on scpt_pkg.
module scpt_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  scpt_pkg::pair_t pair,
    output logic           push,
    output scpt_pkg::work_t push_data
);
    import scpt_pkg::*;

    localparam logic [1:0] K_BB = 2'd0;
    localparam logic [1:0] K_CB = 2'd1;   // A box, B circle
    localparam logic [1:0] K_CA = 2'd2;   // A circle, B box
    localparam logic [1:0] K_CC = 2'd3;

    logic               vld_reg;
    logic [1:0]         kind_reg, kind_next;
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]        hx_reg, hx_next, hy_reg, hy_next, r_reg, r_next;

    logic signed [32:0] a_x, a_y, b_x, b_y;
    logic [32:0]        magx, magy, emx, emy;
    logic signed [33:0] ovx, ovy;
    logic               posx, posy, xaxis, inrange, flip;

    always_comb
    begin
        a_x = $signed({pair.a_center_x[31], pair.a_center_x});
        a_y = $signed({pair.a_center_y[31], pair.a_center_y});
        b_x = $signed({pair.b_center_x[31], pair.b_center_x});
        b_y = $signed({pair.b_center_y[31], pair.b_center_y});
        kind_next = {pair.a_is_circle, pair.b_is_circle};
        dx_next = b_x - a_x;
        dy_next = b_y - a_y;
        hx_next = 32'd0;
        hy_next = 32'd0;
        r_next  = 32'd0;
        case (kind_next)
            K_BB:
            begin
                hx_next = 32'(pair.a_size_x) + 32'(pair.b_size_x);
                hy_next = 32'(pair.a_size_y) + 32'(pair.b_size_y);
            end
            K_CC:
            begin
                r_next = 32'(pair.a_size_x) + 32'(pair.b_size_x);
            end
            K_CA:
            begin
                // measure from box to circle
                dx_next = a_x - b_x;
                dy_next = a_y - b_y;
                hx_next = 32'(pair.b_size_x);
                hy_next = 32'(pair.b_size_y);
                r_next  = 32'(pair.a_size_x);
            end
            default:
            begin
                hx_next = 32'(pair.a_size_x);
                hy_next = 32'(pair.a_size_y);
                r_next  = 32'(pair.b_size_x);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= kind_next;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            hx_reg   <= hx_next;
            hy_reg   <= hy_next;
            r_reg    <= r_next;
        end
    end

    always_comb
    begin
        magx = dx_reg[32] ? 33'(33'd0 - dx_reg) : 33'(dx_reg);
        magy = dy_reg[32] ? 33'(33'd0 - dy_reg) : 33'(dy_reg);
        ovx  = $signed({2'b00, hx_reg}) - $signed({1'b0, magx});
        ovy  = $signed({2'b00, hy_reg}) - $signed({1'b0, magy});
        posx = !ovx[33] && (ovx != 34'sd0);
        posy = !ovy[33] && (ovy != 34'sd0);
        xaxis = ovx < ovy;
        if (kind_reg == K_CC)
        begin
            emx = magx;
            emy = magy;
        end
        else
        begin
            // distance from the clamped point on the box
            emx = (magx > {1'b0, hx_reg}) ? 33'(magx - {1'b0, hx_reg}) : 33'd0;
            emy = (magy > {1'b0, hy_reg}) ? 33'(magy - {1'b0, hy_reg}) : 33'd0;
        end
        inrange = (emx < {1'b0, r_reg}) && (emy < {1'b0, r_reg});
        flip = (kind_reg == K_CA);

        push_data = '0;
        push_data.mx     = emx[31:0];
        push_data.my     = emy[31:0];
        push_data.r      = r_reg;
        push_data.negx   = dx_reg[32] ^ flip;
        push_data.negy   = dy_reg[32] ^ flip;
        push_data.fb_y   = (kind_reg != K_CC);
        push_data.fb_neg = flip;
        if (kind_reg == K_BB)
        begin
            push_data.done = 1'b1;
            if (posx && posy)
            begin
                push_data.res.hit = 1'b1;
                if (xaxis)
                begin
                    push_data.res.normal_x = dx_reg[32] ? N_NEG : N_POS;
                    push_data.res.depth    = ovx[31:0];
                end
                else
                begin
                    push_data.res.normal_y = dy_reg[32] ? N_NEG : N_POS;
                    push_data.res.depth    = ovy[31:0];
                end
            end
        end
        else if (!inrange)
        begin
            push_data.done = 1'b1;
        end
    end

    assign push = vld_reg;

endmodule

// ----- design/scpt_queue.sv -----
// Short queue between front and back; the back drains one word per cycle.
// Depends on scpt_pkg.
module scpt_queue #(
    parameter int DEPTH = scpt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scpt_pkg::work_t wr_data,
    output logic            nearly_full,
    output logic            rd_vld,
    output scpt_pkg::work_t rd_data
);
    import scpt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    work_t           mem [DEPTH];
    logic [AW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]     cnt_reg, cnt_next;
    logic            rd_vld_reg;
    work_t           rd_data_reg;
    logic            pop;

    assign pop = (cnt_reg != '0);

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : AW'(wp_reg + 1'b1);
        if (pop)
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : AW'(rp_reg + 1'b1);
        if (push && !pop)
            cnt_next = (AW+1)'(cnt_reg + 1'b1);
        else if (pop && !push)
            cnt_next = (AW+1)'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_data;
        if (pop)
            rd_data_reg <= mem[rp_reg];
    end

    // leave a slot for the word still in the front stage
    assign nearly_full = (cnt_reg >= (AW+1)'(DEPTH - 1));
    assign rd_vld      = rd_vld_reg;
    assign rd_data     = rd_data_reg;

endmodule

// ----- design/scpt_isqrt.sv -----
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// Depends on scpt_pkg.
module scpt_isqrt (
    input  logic        clk,
    input  logic [63:0] d,
    output logic [31:0] root
);
    import scpt_pkg::*;

    logic [63:0] v_c    [SQRT_STAGES+1];
    logic [33:0] rem_c  [SQRT_STAGES+1];
    logic [31:0] root_c [SQRT_STAGES+1];

    logic [63:0] v_reg    [SQRT_STAGES];
    logic [33:0] rem_reg  [SQRT_STAGES];
    logic [31:0] root_reg [SQRT_STAGES];

    assign v_c[0]    = d;
    assign rem_c[0]  = '0;
    assign root_c[0] = '0;

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        logic [35:0] cur, trial;
        logic        ge;

        always_comb
        begin
            cur   = {rem_c[k], v_c[k][63:62]};
            trial = {2'b00, root_c[k], 2'b01};
            ge    = (cur >= trial);
        end

        always_ff @(posedge clk)
        begin
            v_reg[k]    <= {v_c[k][61:0], 2'b00};
            rem_reg[k]  <= ge ? 34'(cur - trial) : cur[33:0];
            root_reg[k] <= {root_c[k][30:0], ge};
        end

        assign v_c[k+1]    = v_reg[k];
        assign rem_c[k+1]  = rem_reg[k];
        assign root_c[k+1] = root_reg[k];
    end

    assign root = root_c[SQRT_STAGES];

endmodule

// ----- design/scpt_ndiv.sv -----
// Pipelined restoring divider for one normal component, one quotient bit per stage.
// Depends on scpt_pkg.
module scpt_ndiv (
    input  logic                            clk,
    input  logic [47:0]                     num,
    input  logic [32:0]                     den,
    output logic [scpt_pkg::DIV_STAGES-1:0] quo
);
    import scpt_pkg::*;

    logic [47:0]           n_c [DIV_STAGES+1];
    logic [32:0]           d_c [DIV_STAGES+1];
    logic [DIV_STAGES-1:0] q_c [DIV_STAGES+1];

    logic [47:0]           n_reg [DIV_STAGES];
    logic [32:0]           d_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] q_reg [DIV_STAGES];

    assign n_c[0] = num;
    assign d_c[0] = den;
    assign q_c[0] = '0;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        localparam int SH = DIV_STAGES - 1 - k;
        logic [47:0] dsh;
        logic        ge;

        always_comb
        begin
            dsh = 48'(d_c[k]) << SH;
            ge  = (n_c[k] >= dsh);
        end

        always_ff @(posedge clk)
        begin
            n_reg[k] <= ge ? 48'(n_c[k] - dsh) : n_c[k];
            d_reg[k] <= d_c[k];
            q_reg[k] <= {q_c[k][DIV_STAGES-2:0], ge};
        end

        assign n_c[k+1] = n_reg[k];
        assign d_c[k+1] = d_reg[k];
        assign q_c[k+1] = q_reg[k];
    end

    assign quo = q_c[DIV_STAGES];

endmodule

// ----- design/scpt_back.sv -----
// Back end: squared distance, square root, normal division and result assembly.
// Depends on scpt_pkg, scpt_isqrt and scpt_ndiv.
module scpt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  scpt_pkg::work_t   in_data,
    output logic              strobe,
    output scpt_pkg::result_t result
);
    import scpt_pkg::*;

    localparam int LAST = SQRT_STAGES + 1 + DIV_STAGES;

    typedef struct packed {
        work_t w;
        logic  hit;
        logic  zero;
    } side_t;

    logic        vld1_reg;
    work_t       w1_reg;
    logic [63:0] sqx_reg, sqy_reg, rr_reg;

    logic [64:0] d2;
    logic [63:0] d2_reg;
    side_t       side_next;
    side_t       side_root;
    side_t       side_reg [LAST+1];
    logic [LAST:0] vld_reg;

    logic [31:0] root;
    logic [47:0] numx_reg, numy_reg;
    logic [32:0] den_reg;
    logic [DIV_STAGES-1:0] qx, qy;

    logic        out_vld_reg;
    result_t     out_reg, out_next;
    side_t       fin;
    logic [15:0] mx16, my16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld1_reg    <= in_vld;
            vld_reg     <= {vld_reg[LAST-1:0], vld1_reg};
            out_vld_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg  <= in_data;
        sqx_reg <= in_data.mx * in_data.mx;
        sqy_reg <= in_data.my * in_data.my;
        rr_reg  <= in_data.r * in_data.r;
    end

    always_comb
    begin
        d2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        side_next.w    = w1_reg;
        side_next.hit  = (d2 < {1'b0, rr_reg});
        side_next.zero = (d2 == 65'd0);
    end

    always_comb
    begin
        side_root = side_reg[SQRT_STAGES];
        // root lines up with the side word at the end of the square root
        if (!side_root.w.done)
            side_root.w.res.depth = side_reg[SQRT_STAGES].w.r - root;
    end

    always_ff @(posedge clk)
    begin
        d2_reg      <= d2[63:0];
        side_reg[0] <= side_next;
        for (int k = 1; k <= SQRT_STAGES; k++)
            side_reg[k] <= side_reg[k-1];
        side_reg[SQRT_STAGES+1] <= side_root;
        for (int k = SQRT_STAGES + 2; k <= LAST; k++)
            side_reg[k] <= side_reg[k-1];
        numx_reg <= {1'b0, side_reg[SQRT_STAGES].w.mx, 15'd0} + 48'(root);
        numy_reg <= {1'b0, side_reg[SQRT_STAGES].w.my, 15'd0} + 48'(root);
        den_reg  <= {root, 1'b0};
    end

    scpt_isqrt u_isqrt (
        .clk  (clk),
        .d    (d2_reg),
        .root (root)
    );

    scpt_ndiv u_ndiv_x (
        .clk (clk),
        .num (numx_reg),
        .den (den_reg),
        .quo (qx)
    );

    scpt_ndiv u_ndiv_y (
        .clk (clk),
        .num (numy_reg),
        .den (den_reg),
        .quo (qy)
    );

    always_comb
    begin
        fin  = side_reg[LAST];
        mx16 = (qx > DIV_STAGES'(QONE)) ? 16'(QONE) : 16'(qx);
        my16 = (qy > DIV_STAGES'(QONE)) ? 16'(QONE) : 16'(qy);
        out_next = '0;
        if (fin.w.done)
            out_next = fin.w.res;
        else if (fin.hit)
        begin
            out_next.hit   = 1'b1;
            out_next.depth = fin.w.res.depth;
            if (fin.zero)
            begin
                // coincident points: fall back to a fixed axis
                if (fin.w.fb_y)
                    out_next.normal_y = fin.w.fb_neg ? N_NEG : N_POS;
                else
                    out_next.normal_x = N_POS;
            end
            else
            begin
                out_next.normal_x = fin.w.negx ? $signed(16'd0 - mx16) : $signed(mx16);
                out_next.normal_y = fin.w.negy ? $signed(16'd0 - my16) : $signed(my16);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign strobe = out_vld_reg;
    assign result = out_reg;

endmodule

// ----- design/shape_pair_contact_test_core.sv -----
// Top level of the shape pair contact test block.
// Depends on scpt_pkg, scpt_front, scpt_queue and scpt_back.
//
// Usage:
//   Drive a shape pair word on pair and raise start; the word is taken at a
//   rising edge where start is high and busy is low. Each pair gives exactly
//   one result word on result, marked by strobe for a single cycle; the
//   receiver must take it then, as there is no way to hold it off.
//   One pair is accepted every cycle while busy is low: the back end is a fixed
//   pipeline (multiply, add and compare, a 32-stage square root, a 15-stage
//   divider per normal component) that never stalls, so the queue between
//   front and back drains one word per cycle and busy stays low in normal use.
//   busy rises only when that queue nears its depth.
//   Results come out in the order pairs went in.
//   Reset clears all valid flags and queue pointers; words in flight are
//   dropped and no strobe is raised until a new pair is taken.
module shape_pair_contact_test_core #(
    parameter int QUEUE_DEPTH = scpt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  scpt_pkg::pair_t   pair,
    output logic              strobe,
    output scpt_pkg::result_t result
);
    import scpt_pkg::*;

    logic  take, push, q_full, q_vld;
    work_t push_data, q_data;

    assign take = start && !busy;
    assign busy = q_full;

    scpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .pair      (pair),
        .push      (push),
        .push_data (push_data)
    );

    scpt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .wr_data     (push_data),
        .nearly_full (q_full),
        .rd_vld      (q_vld),
        .rd_data     (q_data)
    );

    scpt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (q_vld),
        .in_data (q_data),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

// ----- verif/tb_shape_pair_contact_test_core.sv -----
// Self-checking bench for shape_pair_contact_test_core: random and corner shape pairs,
// predicted in the bench and compared word by word against the strobed results.
// Depends on scpt_pkg and the RTL of shape_pair_contact_test_core.
`timescale 1ns / 100ps

module tb_shape_pair_contact_test_core;
    import scpt_pkg::*;

    localparam int LATENCY    = 54;
    localparam int MAX_CYCLES = 400000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    pair_t   pair;
    logic    strobe;
    result_t result;

    result_t contact_q[$];
    int      n_fail;
    int      n_pairs;
    int      n_hits;
    int      n_words;
    longint  cycle_cnt;

    shape_pair_contact_test_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pair   (pair),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bit-by-bit square root of a 64-bit value, truncated
    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // One normal component, rounded half away from zero, Q2.14
    function automatic longint norm_part(longint c, longint unsigned s);
        longint unsigned q;
        q = (2 * 64'd16384 * abs64(c) + s) / (2 * s);
        if (q > 16384)
            q = 16384;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Circle against box; normal from box to circle
    function automatic bit circle_box(longint cx, longint cy, longint unsigned r,
                                      longint bx, longint by, longint hx, longint hy,
                                      output longint nx, output longint ny,
                                      output longint unsigned dep);
        longint dx, dy, kx, ky, ex, ey;
        longint unsigned mx, my, d2, s;
        nx  = 0;
        ny  = 0;
        dep = 0;
        dx  = cx - bx;
        dy  = cy - by;
        kx  = (dx < -hx) ? -hx : ((dx > hx) ? hx : dx);
        ky  = (dy < -hy) ? -hy : ((dy > hy) ? hy : dy);
        ex  = dx - kx;
        ey  = dy - ky;
        mx  = abs64(ex);
        my  = abs64(ey);
        if (mx >= r || my >= r)
            return 1'b0;
        d2 = mx * mx + my * my;
        if (d2 >= r * r)
            return 1'b0;
        s = root64(d2);
        if (d2 == 0 || s == 0)
        begin
            nx = 0;
            ny = 16384;
        end
        else
        begin
            nx = norm_part(ex, s);
            ny = norm_part(ey, s);
        end
        dep = r - s;
        return 1'b1;
    endfunction

    function automatic result_t predict_contact(pair_t p);
        result_t         res;
        longint          ax, ay, bx, by, ahx, ahy, bhx, bhy, dx, dy, ox, oy, nx, ny;
        longint unsigned dep, r, mx, my, sq1, d2, s;
        bit              hit;
        ax  = longint'(p.a_center_x);
        ay  = longint'(p.a_center_y);
        bx  = longint'(p.b_center_x);
        by  = longint'(p.b_center_y);
        ahx = longint'({1'b0, p.a_size_x});
        ahy = longint'({1'b0, p.a_size_y});
        bhx = longint'({1'b0, p.b_size_x});
        bhy = longint'({1'b0, p.b_size_y});
        nx  = 0;
        ny  = 0;
        dep = 0;
        hit = 1'b0;
        dx  = bx - ax;
        dy  = by - ay;
        if (!p.a_is_circle && !p.b_is_circle)
        begin
            ox = (ahx + bhx) - longint'(abs64(dx));
            oy = (ahy + bhy) - longint'(abs64(dy));
            if (ox > 0 && oy > 0)
            begin
                hit = 1'b1;
                if (ox < oy)
                begin
                    nx  = (dx < 0) ? -16384 : 16384;
                    dep = ox;
                end
                else
                begin
                    ny  = (dy < 0) ? -16384 : 16384;
                    dep = oy;
                end
            end
        end
        else if (p.a_is_circle && p.b_is_circle)
        begin
            r  = ahx + bhx;
            mx = abs64(dx);
            my = abs64(dy);
            if (mx < r && my < r)
            begin
                sq1 = mx * mx;
                d2  = sq1 + my * my;
                if (d2 >= sq1 && d2 < r * r)
                begin
                    hit = 1'b1;
                    s   = root64(d2);
                    if (d2 == 0 || s == 0)
                    begin
                        nx = 16384;
                        ny = 0;
                    end
                    else
                    begin
                        nx = norm_part(dx, s);
                        ny = norm_part(dy, s);
                    end
                    dep = r - s;
                end
            end
        end
        else if (p.a_is_circle)
        begin
            hit = circle_box(ax, ay, ahx, bx, by, bhx, bhy, nx, ny, dep);
            nx  = -nx;
            ny  = -ny;
        end
        else
            hit = circle_box(bx, by, bhx, ax, ay, ahx, ahy, nx, ny, dep);
        if (!hit)
        begin
            nx  = 0;
            ny  = 0;
            dep = 0;
        end
        res.hit      = hit;
        res.normal_x = nx[15:0];
        res.normal_y = ny[15:0];
        res.depth    = dep[31:0];
        return res;
    endfunction

    // Drive one word after a random gap and hold it until taken
    task automatic send_pair(pair_t p, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        pair  <= p;
        start <= 1'b1;
        // busy only moves at a rising edge, so its value here holds for the next edge
        while (busy)
            @(negedge clk);
        @(posedge clk);
        contact_q.insert(contact_q.size(), predict_contact(p));
        n_pairs++;
    endtask

    // Check each strobed word against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        cycle_cnt++;
        if (rst_n && strobe)
        begin
            n_words++;
            if (contact_q.size() == 0)
            begin
                $error("result word with no pair outstanding");
                n_fail++;
            end
            else
            begin
                want = contact_q.pop_front();
                if (want.hit)
                    n_hits++;
                if (result.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, result.hit);
                    n_fail++;
                end
                if (result.normal_x !== want.normal_x)
                begin
                    $error("normal_x: expected %0d, got %0d", want.normal_x,
                           result.normal_x);
                    n_fail++;
                end
                if (result.normal_y !== want.normal_y)
                begin
                    $error("normal_y: expected %0d, got %0d", want.normal_y,
                           result.normal_y);
                    n_fail++;
                end
                if (result.depth !== want.depth)
                begin
                    $error("depth: expected %0d, got %0d", want.depth, result.depth);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin
        wait (cycle_cnt >= MAX_CYCLES);
        $display("shape_pair_contact_test_core: mismatch");
        $finish;
    end

    function automatic pair_t mk_pair(bit ac, longint ax, longint ay, longint asx,
                                      longint asy, bit bc, longint bx, longint by,
                                      longint bsx, longint bsy);
        pair_t p;
        p.a_is_circle = ac;
        p.a_center_x  = ax[31:0];
        p.a_center_y  = ay[31:0];
        p.a_size_x    = asx[30:0];
        p.a_size_y    = asy[30:0];
        p.b_is_circle = bc;
        p.b_center_x  = bx[31:0];
        p.b_center_y  = by[31:0];
        p.b_size_x    = bsx[30:0];
        p.b_size_y    = bsy[30:0];
        return p;
    endfunction

    // Nearby shapes, so that hits are common; scale spans small to huge
    function automatic pair_t rand_near_pair();
        pair_t  p;
        int     sh;
        longint base_x, base_y;
        sh     = $urandom_range(4, 30);
        base_x = longint'($signed($urandom));
        base_y = longint'($signed($urandom));
        p      = mk_pair($urandom_range(0, 1),
                         base_x, base_y,
                         $urandom & ((64'd1 << sh) - 1), $urandom & ((64'd1 << sh) - 1),
                         $urandom_range(0, 1),
                         base_x + (longint'($signed($urandom)) >>> (32 - sh)),
                         base_y + (longint'($signed($urandom)) >>> (32 - sh)),
                         $urandom & ((64'd1 << sh) - 1), $urandom & ((64'd1 << sh) - 1));
        return p;
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (contact_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_box_box();
        send_pair(mk_pair(0, 0, 0, 65536, 65536, 0, 32768, 0, 65536, 65536));
        send_pair(mk_pair(0, 0, 0, 65536, 65536, 0, 0, -32768, 65536, 65536));
        // equal overlaps: Y wins
        send_pair(mk_pair(0, 0, 0, 65536, 65536, 0, -32768, -32768, 65536, 65536));
        // touching exactly
        send_pair(mk_pair(0, 0, 0, 65536, 65536, 0, 131072, 0, 65536, 65536));
        send_pair(mk_pair(0, -2147483648, -2147483648, 2147483647, 2147483647,
                          0, 2147483647, 2147483647, 2147483647, 2147483647));
        send_pair(mk_pair(0, 2147483647, -2147483648, 0, 0,
                          0, 2147483647, -2147483648, 0, 0));
    endtask

    task automatic test_circle_circle();
        send_pair(mk_pair(1, 0, 0, 65536, 0, 1, 0, 0, 65536, 0));
        send_pair(mk_pair(1, 0, 0, 65536, 0, 1, 65536, 65536, 65536, 0));
        send_pair(mk_pair(1, 0, 0, 65536, 0, 1, -131072, 0, 65536, 0));
        send_pair(mk_pair(1, 0, 0, 1, 0, 1, 1, 0, 1, 0));
        send_pair(mk_pair(1, -2147483648, -2147483648, 2147483647, 2147483647,
                          1, 2147483647, 2147483647, 2147483647, 2147483647));
        send_pair(mk_pair(1, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    endtask

    task automatic test_circle_box();
        send_pair(mk_pair(1, 0, 0, 65536, 0, 0, 0, 0, 65536, 65536));
        send_pair(mk_pair(0, 0, 0, 65536, 65536, 1, 0, 0, 65536, 0));
        send_pair(mk_pair(1, 150000, 150000, 65536, 0, 0, 0, 0, 65536, 65536));
        send_pair(mk_pair(0, 0, 0, 65536, 65536, 1, -150000, 70000, 65536, 0));
        // touching a face exactly
        send_pair(mk_pair(1, 196608, 0, 65536, 0, 0, 0, 0, 131072, 65536));
        send_pair(mk_pair(0, -2147483648, 2147483647, 2147483647, 2147483647,
                          1, 2147483647, -2147483648, 2147483647, 0));
        send_pair(mk_pair(1, 0, 0, 2147483647, 2147483647, 0, 100, -100, 0, 0));
    endtask

    task automatic test_random();
        pair_t p;
        for (int i = 0; i < 920; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                p = rand_near_pair();
            else
                p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, 30'($urandom)});
            // stretches with no gaps
            send_pair(p, (i / 100) % 3 == 1);
            if (i == 450)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        pair      = '0;
        n_fail    = 0;
        n_pairs   = 0;
        n_hits    = 0;
        n_words   = 0;
        cycle_cnt = 0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_box_box();
        test_circle_circle();
        test_circle_box();
        test_random();
        wait_drained();
        repeat (LATENCY + 10)
            @(negedge clk);
        $display("Sent %0d shape pairs of all kind mixes, %0d of them overlapping.",
                 n_pairs, n_hits);
        if (n_fail == 0 && contact_q.size() == 0)
            $display("shape_pair_contact_test_core: match");
        else
            $display("shape_pair_contact_test_core: mismatch");
        $finish;
    end

endmodule

// ----- shape_pair_contact_test_core.f -----
design/scpt_pkg.sv
design/scpt_front.sv
design/scpt_queue.sv
design/scpt_isqrt.sv
design/scpt_ndiv.sv
design/scpt_back.sv
design/shape_pair_contact_test_core.sv
verif/tb_shape_pair_contact_test_core.sv
